// ===== hw/rtl/rtas_pkg.sv =====
// Shared types, constants and elaboration-time helpers for the antenna-frame CORDIC pipeline.
package rtas_pkg;

    typedef logic signed [63:0] data_t;
    typedef logic signed [33:0] ang_t;

    localparam ang_t QUARTER   = ang_t'(64'd1 << 30);
    localparam ang_t HALF_TURN = ang_t'(64'd1 << 31);

    localparam logic [7:0] CFG_AZIMUTH_OFFSET = 8'd0;
    localparam logic [7:0] CFG_ELEVATION_TILT = 8'd1;

    // atan(2^-i) in units of 2^32 per turn
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
    };

    // Magnitude left by the vectoring iterations on (2^30, 0)
    function automatic longint cordic_gain_mag(input int stages);
        longint a;
        longint b;
        longint dx;
        longint dy;
        a = longint'(64'd1 << 30);
        b = 0;
        for (int i = 0; i < stages; i++)
        begin
            dx = b >>> i;
            dy = a >>> i;
            if (b >= 0)
            begin
                a = a + dx;
                b = b - dy;
            end
            else
            begin
                a = a - dx;
                b = b + dy;
            end
        end
        if (a <= 0)
        begin
            a = 1;
        end
        return a;
    endfunction

endpackage

// ===== hw/rtl/rtas_cell.sv =====
// One CORDIC micro-rotation cell, rotating or vectoring, with a registered output.
module rtas_cell
    import rtas_pkg::*;
#(
    parameter int STAGE  = 0,
    parameter bit VECTOR = 1'b0,
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  data_t             in_x,
    input  data_t             in_y,
    input  ang_t              in_ang,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output data_t             out_x,
    output data_t             out_y,
    output ang_t              out_ang,
    output logic [SIDE_W-1:0] out_side
);

    localparam ang_t STEP_ANG = ang_t'({2'b00, ATAN_TAB[STAGE]});

    logic              valid_reg;
    data_t             x_reg;
    data_t             x_next;
    data_t             y_reg;
    data_t             y_next;
    ang_t              ang_reg;
    ang_t              ang_next;
    logic [SIDE_W-1:0] side_reg;
    logic              turn_pos;
    data_t             dx;
    data_t             dy;

    always_comb
    begin
        dx       = in_y >>> STAGE;
        dy       = in_x >>> STAGE;
        turn_pos = VECTOR ? (in_y < 0) : (in_ang >= 0);
        if (turn_pos)
        begin
            x_next   = in_x - dx;
            y_next   = in_y + dy;
            ang_next = in_ang - STEP_ANG;
        end
        else
        begin
            x_next   = in_x + dx;
            y_next   = in_y - dy;
            ang_next = in_ang + STEP_ANG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        ang_reg  <= ang_next;
        side_reg <= in_side;
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_ang   = ang_reg;
    assign out_side  = side_reg;

endmodule

// ===== hw/rtl/rtas_row.sv =====
// A chain of CORDIC cells, one iteration per cell.
module rtas_row
    import rtas_pkg::*;
#(
    parameter int STAGES = 18,
    parameter bit VECTOR = 1'b0,
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  data_t             in_x,
    input  data_t             in_y,
    input  ang_t              in_ang,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output data_t             out_x,
    output data_t             out_y,
    output ang_t              out_ang,
    output logic [SIDE_W-1:0] out_side
);

    logic [STAGES:0]   v_chain;
    data_t             x_chain    [STAGES+1];
    data_t             y_chain    [STAGES+1];
    ang_t              ang_chain  [STAGES+1];
    logic [SIDE_W-1:0] side_chain [STAGES+1];

    assign v_chain[0]    = in_valid;
    assign x_chain[0]    = in_x;
    assign y_chain[0]    = in_y;
    assign ang_chain[0]  = in_ang;
    assign side_chain[0] = in_side;

    for (genvar i = 0; i < STAGES; i++)
    begin : g_cell
        rtas_cell #(
            .STAGE  (i),
            .VECTOR (VECTOR),
            .SIDE_W (SIDE_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v_chain[i]),
            .in_x      (x_chain[i]),
            .in_y      (y_chain[i]),
            .in_ang    (ang_chain[i]),
            .in_side   (side_chain[i]),
            .out_valid (v_chain[i+1]),
            .out_x     (x_chain[i+1]),
            .out_y     (y_chain[i+1]),
            .out_ang   (ang_chain[i+1]),
            .out_side  (side_chain[i+1])
        );
    end

    assign out_valid = v_chain[STAGES];
    assign out_x     = x_chain[STAGES];
    assign out_y     = y_chain[STAGES];
    assign out_ang   = ang_chain[STAGES];
    assign out_side  = side_chain[STAGES];

endmodule

// ===== hw/rtl/rtas_scale.sv =====
// Two-stage gain correction: multiply by a Q31 constant, rounding half away from zero.
module rtas_scale
    import rtas_pkg::*;
#(
    parameter logic [30:0] KI     = 31'd1304065748,
    parameter int          LANES  = 1,
    parameter int          SIDE_W = 1
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [LANES-1:0][63:0] in_v,
    input  logic [SIDE_W-1:0]      in_side,
    output logic                   out_valid,
    output logic [LANES-1:0][63:0] out_v,
    output logic [SIDE_W-1:0]      out_side
);

    logic                   va_reg;
    logic                   vb_reg;
    logic [LANES-1:0][63:0] hi_reg;
    logic [LANES-1:0][63:0] hi_next;
    logic [LANES-1:0][63:0] lo_reg;
    logic [LANES-1:0][63:0] lo_next;
    logic [LANES-1:0]       neg_reg;
    logic [LANES-1:0]       neg_next;
    logic [LANES-1:0][63:0] res_reg;
    logic [LANES-1:0][63:0] res_next;
    logic [SIDE_W-1:0]      sa_reg;
    logic [SIDE_W-1:0]      sb_reg;
    logic [63:0]            mag;
    logic [63:0]            prod;

    // Split the magnitude at bit 31 so each product stays near 32 by 32
    always_comb
    begin
        mag = '0;
        for (int i = 0; i < LANES; i++)
        begin
            neg_next[i] = in_v[i][63];
            mag         = in_v[i][63] ? (64'd0 - in_v[i]) : in_v[i];
            hi_next[i]  = 64'(mag[63:31]) * 64'(KI);
            lo_next[i]  = 64'(mag[30:0]) * 64'(KI);
        end
    end

    always_comb
    begin
        prod = '0;
        for (int i = 0; i < LANES; i++)
        begin
            prod        = hi_reg[i] + ((lo_reg[i] + 64'h4000_0000) >> 31);
            res_next[i] = neg_reg[i] ? (64'd0 - prod) : prod;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
        neg_reg <= neg_next;
        sa_reg  <= in_side;
        res_reg <= res_next;
        sb_reg  <= sa_reg;
    end

    assign out_valid = vb_reg;
    assign out_v     = res_reg;
    assign out_side  = sb_reg;

endmodule

// ===== hw/rtl/rotate_to_antenna_spherical.sv =====
// Top level: rotates a target into the antenna frame and returns azimuth, elevation, range.
//
// Usage
//   Present pos_north, pos_west, pos_up with start high; an item is taken at every
//   rising edge where start is high and busy is low. busy never rises, so one item
//   can enter every cycle with no gaps.
//   Each result appears on azimuth, elevation and range_len with done high for
//   exactly one cycle, in the order the items were taken. The receiver cannot
//   stall; results leave at full rate.
//   The pipeline is four chains of CORDIC cells, each followed by a two-stage gain
//   multiplier, plus prestep, input and output registers. Throughput is one item
//   per cycle.
//   The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
//   azimuth_offset at index 0 and elevation_tilt at index 1; other indexes are
//   ignored. cfg_ready is always high. Write only while no item is in flight.
//   Reset clears both registers to zero and drops every item in the pipeline.
module rotate_to_antenna_spherical
    import rtas_pkg::*;
#(
    parameter int COORD_WIDTH   = 32,
    parameter int ANGLE_WIDTH   = 16,
    parameter int CORDIC_STAGES = 18
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] pos_north,
    input  logic [31:0] pos_west,
    input  logic [31:0] pos_up,
    output logic        done,
    output logic [15:0] azimuth,
    output logic [15:0] elevation,
    output logic [31:0] range_len,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int          GUARD      = 61 - COORD_WIDTH;
    localparam int          SEXT_SHIFT = 64 - COORD_WIDTH;
    localparam int          ASHIFT     = 32 - ANGLE_WIDTH;
    localparam int          LATENCY    = 4 * CORDIC_STAGES + 14;
    localparam longint      GAIN_MAG   = cordic_gain_mag(CORDIC_STAGES);
    localparam logic [30:0] KI         = 31'(((64'd1 << 61) + GAIN_MAG / 2) / GAIN_MAG);
    localparam logic [32:0] AZ_HALF    = 33'd1 << (ASHIFT - 1);
    localparam ang_t        EL_HALF    = ang_t'(64'd1 << (ASHIFT - 1));
    localparam logic [64:0] RNG_HALF   = 65'd1 << (GUARD - 1);
    localparam int          SIDE_C     = 130;
    localparam int          SIDE_SC    = 129 + ANGLE_WIDTH;
    localparam int          SIDE_D     = 65 + ANGLE_WIDTH;
    localparam int          SIDE_SD    = 81 + ANGLE_WIDTH;

    // Configuration registers
    logic [15:0] azoff_reg;
    logic [15:0] tilt_reg;
    logic        cfg_write;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            azoff_reg <= '0;
            tilt_reg  <= '0;
        end
        else if (cfg_write)
        begin
            priority if (cfg_index == CFG_AZIMUTH_OFFSET)
            begin
                azoff_reg <= cfg_data;
            end
            else if (cfg_index == CFG_ELEVATION_TILT)
            begin
                tilt_reg <= cfg_data;
            end
        end
    end

    logic [31:0] az_word;
    logic [31:0] tilt_word;

    assign az_word   = {16'd0, azoff_reg} << ASHIFT;
    assign tilt_word = {16'd0, tilt_reg} << ASHIFT;

    // Input register: sign-extend the low COORD_WIDTH bits and scale by 2^GUARD
    logic  in_valid_reg;
    data_t in_x_reg;
    data_t in_x_next;
    data_t in_y_reg;
    data_t in_y_next;
    data_t in_z_reg;
    data_t in_z_next;
    logic  accept;

    assign accept    = start && !busy;
    assign in_x_next = $signed({32'd0, pos_north} << SEXT_SHIFT) >>> 3;
    assign in_y_next = $signed({32'd0, pos_west} << SEXT_SHIFT) >>> 3;
    assign in_z_next = $signed({32'd0, pos_up} << SEXT_SHIFT) >>> 3;

    // Prestep 1: fold the azimuth rotation into a quarter turn
    logic  p1_valid_reg;
    data_t p1_x_reg;
    data_t p1_x_next;
    data_t p1_y_reg;
    data_t p1_y_next;
    ang_t  p1_ang_reg;
    ang_t  p1_ang_next;
    data_t p1_z_reg;
    ang_t  r1;

    always_comb
    begin
        r1 = ang_t'($signed(az_word));
        if (r1 > QUARTER || r1 < -QUARTER)
        begin
            p1_x_next   = -in_x_reg;
            p1_y_next   = -in_y_reg;
            p1_ang_next = (r1 > 0) ? (r1 - HALF_TURN) : (r1 + HALF_TURN);
        end
        else
        begin
            p1_x_next   = in_x_reg;
            p1_y_next   = in_y_reg;
            p1_ang_next = r1;
        end
    end

    logic         a_valid;
    data_t        a_x;
    data_t        a_y;
    logic [63:0]  a_side;

    rtas_row #(
        .STAGES (CORDIC_STAGES),
        .VECTOR (1'b0),
        .SIDE_W (64)
    ) u_row_az (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p1_valid_reg),
        .in_x      (p1_x_reg),
        .in_y      (p1_y_reg),
        .in_ang    (p1_ang_reg),
        .in_side   (p1_z_reg),
        .out_valid (a_valid),
        .out_x     (a_x),
        .out_y     (a_y),
        .out_ang   (),
        .out_side  (a_side)
    );

    logic             sa_valid;
    logic [1:0][63:0] sa_v;
    logic [63:0]      sa_side;

    rtas_scale #(
        .KI     (KI),
        .LANES  (2),
        .SIDE_W (64)
    ) u_scale_az (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_valid),
        .in_v      ({a_y, a_x}),
        .in_side   (a_side),
        .out_valid (sa_valid),
        .out_v     (sa_v),
        .out_side  (sa_side)
    );

    // Prestep 2: rotate (z, x1) by the tilt
    logic  p2_valid_reg;
    data_t p2_x_reg;
    data_t p2_x_next;
    data_t p2_y_reg;
    data_t p2_y_next;
    ang_t  p2_ang_reg;
    ang_t  p2_ang_next;
    data_t p2_side_reg;
    ang_t  r2;

    always_comb
    begin
        r2 = ang_t'($signed(tilt_word));
        if (r2 > QUARTER || r2 < -QUARTER)
        begin
            p2_x_next   = -$signed(sa_side);
            p2_y_next   = -$signed(sa_v[0]);
            p2_ang_next = (r2 > 0) ? (r2 - HALF_TURN) : (r2 + HALF_TURN);
        end
        else
        begin
            p2_x_next   = $signed(sa_side);
            p2_y_next   = $signed(sa_v[0]);
            p2_ang_next = r2;
        end
    end

    logic        b_valid;
    data_t       b_x;
    data_t       b_y;
    logic [63:0] b_side;

    rtas_row #(
        .STAGES (CORDIC_STAGES),
        .VECTOR (1'b0),
        .SIDE_W (64)
    ) u_row_tilt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p2_valid_reg),
        .in_x      (p2_x_reg),
        .in_y      (p2_y_reg),
        .in_ang    (p2_ang_reg),
        .in_side   (p2_side_reg),
        .out_valid (b_valid),
        .out_x     (b_x),
        .out_y     (b_y),
        .out_ang   (),
        .out_side  (b_side)
    );

    logic             sb_valid;
    logic [1:0][63:0] sb_v;
    logic [63:0]      sb_side;

    rtas_scale #(
        .KI     (KI),
        .LANES  (2),
        .SIDE_W (64)
    ) u_scale_tilt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_valid),
        .in_v      ({b_y, b_x}),
        .in_side   (b_side),
        .out_valid (sb_valid),
        .out_v     (sb_v),
        .out_side  (sb_side)
    );

    // Prestep 3: vector (x2, y1) for azimuth; keep the on-axis case aside
    logic              p3_valid_reg;
    data_t             p3_x_reg;
    data_t             p3_x_next;
    data_t             p3_y_reg;
    data_t             p3_y_next;
    ang_t              p3_ang_reg;
    ang_t              p3_ang_next;
    logic [SIDE_C-1:0] p3_side_reg;
    logic [SIDE_C-1:0] p3_side_next;
    data_t             x2;
    data_t             y1;
    data_t             z2;
    data_t             abs_x2;

    always_comb
    begin
        z2     = $signed(sb_v[0]);
        x2     = $signed(sb_v[1]);
        y1     = $signed(sb_side);
        abs_x2 = (x2 < 0) ? -x2 : x2;
        p3_side_next = {z2, abs_x2, (y1 == 0), (x2 > 0)};
        if (x2 < 0)
        begin
            p3_x_next   = -x2;
            p3_y_next   = -y1;
            p3_ang_next = HALF_TURN;
        end
        else
        begin
            p3_x_next   = x2;
            p3_y_next   = y1;
            p3_ang_next = '0;
        end
    end

    logic              c_valid;
    data_t             c_x;
    ang_t              c_ang;
    logic [SIDE_C-1:0] c_side;

    rtas_row #(
        .STAGES (CORDIC_STAGES),
        .VECTOR (1'b1),
        .SIDE_W (SIDE_C)
    ) u_row_azv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p3_valid_reg),
        .in_x      (p3_x_reg),
        .in_y      (p3_y_reg),
        .in_ang    (p3_ang_reg),
        .in_side   (p3_side_reg),
        .out_valid (c_valid),
        .out_x     (c_x),
        .out_y     (),
        .out_ang   (c_ang),
        .out_side  (c_side)
    );

    // Round the azimuth to ANGLE_WIDTH bits; on the x axis it is 0 or a half turn
    logic [32:0]            az_sum;
    logic [ANGLE_WIDTH-1:0] az_code;
    logic [SIDE_SC-1:0]     sc_side_in;

    always_comb
    begin
        az_sum = {1'b0, c_ang[31:0]} + AZ_HALF;
        if (c_side[1])
        begin
            az_code = c_side[0] ? '0 : {1'b1, {(ANGLE_WIDTH-1){1'b0}}};
        end
        else
        begin
            az_code = az_sum[ASHIFT +: ANGLE_WIDTH];
        end
        sc_side_in = {c_side[129:66], c_side[65:2], c_side[1], az_code};
    end

    logic               sc_valid;
    logic [0:0][63:0]   sc_v;
    logic [SIDE_SC-1:0] sc_side;

    rtas_scale #(
        .KI     (KI),
        .LANES  (1),
        .SIDE_W (SIDE_SC)
    ) u_scale_rxy (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_valid),
        .in_v      (c_x),
        .in_side   (sc_side_in),
        .out_valid (sc_valid),
        .out_v     (sc_v),
        .out_side  (sc_side)
    );

    // Prestep 4: vector (rxy, z2) for elevation
    logic              p4_valid_reg;
    data_t             p4_x_reg;
    data_t             p4_x_next;
    data_t             p4_y_reg;
    data_t             p4_y_next;
    ang_t              p4_ang_reg;
    ang_t              p4_ang_next;
    logic [SIDE_D-1:0] p4_side_reg;
    logic [SIDE_D-1:0] p4_side_next;
    data_t             rxy;
    data_t             z2c;

    always_comb
    begin
        z2c = $signed(sc_side[SIDE_SC-1 -: 64]);
        rxy = sc_side[ANGLE_WIDTH] ? $signed(sc_side[ANGLE_WIDTH+64 -: 64])
                                   : $signed(sc_v[0]);
        p4_side_next = {rxy, (z2c == 0), sc_side[ANGLE_WIDTH-1:0]};
        if (rxy < 0)
        begin
            p4_x_next   = -rxy;
            p4_y_next   = -z2c;
            p4_ang_next = HALF_TURN;
        end
        else
        begin
            p4_x_next   = rxy;
            p4_y_next   = z2c;
            p4_ang_next = '0;
        end
    end

    logic              d_valid;
    data_t             d_x;
    ang_t              d_ang;
    logic [SIDE_D-1:0] d_side;

    rtas_row #(
        .STAGES (CORDIC_STAGES),
        .VECTOR (1'b1),
        .SIDE_W (SIDE_D)
    ) u_row_elv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p4_valid_reg),
        .in_x      (p4_x_reg),
        .in_y      (p4_y_reg),
        .in_ang    (p4_ang_reg),
        .in_side   (p4_side_reg),
        .out_valid (d_valid),
        .out_x     (d_x),
        .out_y     (),
        .out_ang   (d_ang),
        .out_side  (d_side)
    );

    // Clamp the elevation to a quarter turn and round
    ang_t               el_clamp;
    ang_t               el_full;
    logic [SIDE_SD-1:0] sd_side_in;

    always_comb
    begin
        if (d_ang > QUARTER)
        begin
            el_clamp = QUARTER;
        end
        else if (d_ang < -QUARTER)
        begin
            el_clamp = -QUARTER;
        end
        else
        begin
            el_clamp = d_ang;
        end
        el_full    = (el_clamp + EL_HALF) >>> ASHIFT;
        sd_side_in = {d_side, el_full[15:0]};
    end

    logic               sd_valid;
    logic [0:0][63:0]   sd_v;
    logic [SIDE_SD-1:0] sd_side;

    rtas_scale #(
        .KI     (KI),
        .LANES  (1),
        .SIDE_W (SIDE_SD)
    ) u_scale_rng (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d_valid),
        .in_v      (d_x),
        .in_side   (sd_side_in),
        .out_valid (sd_valid),
        .out_v     (sd_v),
        .out_side  (sd_side)
    );

    // Output stage: pick the range, round from the guard scale, saturate
    logic        done_reg;
    logic [15:0] azimuth_reg;
    logic [15:0] azimuth_next;
    logic [15:0] elevation_reg;
    logic [15:0] elevation_next;
    logic [31:0] range_reg;
    logic [31:0] range_next;
    data_t       r_sel;
    logic [64:0] r_sum;
    logic [64:0] r_rnd;
    logic        z_zero;

    always_comb
    begin
        z_zero = sd_side[ANGLE_WIDTH+16];
        r_sel  = z_zero ? $signed(sd_side[SIDE_SD-1 -: 64]) : $signed(sd_v[0]);
        if (r_sel < 0)
        begin
            r_sel = '0;
        end
        r_sum = {1'b0, r_sel} + RNG_HALF;
        r_rnd = r_sum >> GUARD;
        range_next     = (r_rnd > 65'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : r_rnd[31:0];
        azimuth_next   = 16'($signed(sd_side[ANGLE_WIDTH+15 -: ANGLE_WIDTH]));
        elevation_next = z_zero ? 16'd0 : sd_side[15:0];
    end

    // Valid pipeline of the hand-built stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
            p1_valid_reg <= in_valid_reg;
            p2_valid_reg <= sa_valid;
            p3_valid_reg <= sb_valid;
            p4_valid_reg <= sc_valid;
            done_reg     <= sd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        in_x_reg      <= in_x_next;
        in_y_reg      <= in_y_next;
        in_z_reg      <= in_z_next;
        p1_x_reg      <= p1_x_next;
        p1_y_reg      <= p1_y_next;
        p1_ang_reg    <= p1_ang_next;
        p1_z_reg      <= in_z_reg;
        p2_x_reg      <= p2_x_next;
        p2_y_reg      <= p2_y_next;
        p2_ang_reg    <= p2_ang_next;
        p2_side_reg   <= $signed(sa_v[1]);
        p3_x_reg      <= p3_x_next;
        p3_y_reg      <= p3_y_next;
        p3_ang_reg    <= p3_ang_next;
        p3_side_reg   <= p3_side_next;
        p4_x_reg      <= p4_x_next;
        p4_y_reg      <= p4_y_next;
        p4_ang_reg    <= p4_ang_next;
        p4_side_reg   <= p4_side_next;
        azimuth_reg   <= azimuth_next;
        elevation_reg <= elevation_next;
        range_reg     <= range_next;
    end

    assign done      = done_reg;
    assign azimuth   = azimuth_reg;
    assign elevation = elevation_reg;
    assign range_len = range_reg;

`ifndef SYNTHESIS
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("result strobe missing at fixed latency");

    a_cfg_az : assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write && cfg_index == CFG_AZIMUTH_OFFSET |=> azoff_reg == $past(cfg_data))
        else $error("azimuth offset not written");

    a_cfg_tilt : assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write && cfg_index == CFG_ELEVATION_TILT |=> tilt_reg == $past(cfg_data))
        else $error("elevation tilt not written");
`endif

endmodule

// ===== verif/rtas_checker.sv =====
// Checker for the antenna-frame CORDIC block: predicts each item's result and compares.
module rtas_checker
    import rtas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [31:0] pos_north,
    input  logic [31:0] pos_west,
    input  logic [31:0] pos_up,
    input  logic        done,
    input  logic [15:0] azimuth,
    input  logic [15:0] elevation,
    input  logic [31:0] range_len,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          errors,
    output int          pending
);

    localparam int STAGES = 18;
    localparam int GUARD  = 29;

    typedef struct packed {
        logic [15:0] az;
        logic [15:0] el;
        logic [31:0] rng;
    } polar_t;

    polar_t          polar_q[$];
    logic [15:0]     az_offset;
    logic [15:0]     el_tilt;
    longint unsigned inv_k;

    function automatic longint q31_mul(input longint v, input longint unsigned c);
        longint unsigned m;
        longint unsigned p;
        m = (v < 0) ? longint'(-v) : longint'(v);
        p = (m >> 31) * c + (((m & 64'h7FFF_FFFF) * c + 64'h4000_0000) >> 31);
        return (v < 0) ? -longint'(p) : longint'(p);
    endfunction

    // Rotate (a, b) counterclockwise by ang turns/2^32; the gain stays in.
    function automatic void spin(inout longint a, inout longint b, input logic [31:0] ang);
        longint r;
        longint dx;
        longint dy;
        r = longint'($signed(ang));
        if (r > (64'sd1 <<< 30) || r < -(64'sd1 <<< 30))
        begin
            a = -a;
            b = -b;
            r = (r > 0) ? r - (64'sd1 <<< 31) : r + (64'sd1 <<< 31);
        end
        for (int i = 0; i < STAGES; i++)
        begin
            dx = b >>> i;
            dy = a >>> i;
            if (r >= 0)
            begin
                a = a - dx;
                b = b + dy;
                r = r - longint'(ATAN_TAB[i]);
            end
            else
            begin
                a = a + dx;
                b = b - dy;
                r = r + longint'(ATAN_TAB[i]);
            end
        end
    endfunction

    // Drive b to zero; return the angle, leave the gained magnitude in a.
    function automatic longint aim(inout longint a, inout longint b);
        longint acc;
        longint dx;
        longint dy;
        acc = 0;
        if (a < 0)
        begin
            a = -a;
            b = -b;
            acc = 64'sd1 <<< 31;
        end
        for (int i = 0; i < STAGES; i++)
        begin
            dx = b >>> i;
            dy = a >>> i;
            if (b >= 0)
            begin
                a = a + dx;
                b = b - dy;
                acc = acc + longint'(ATAN_TAB[i]);
            end
            else
            begin
                a = a - dx;
                b = b + dy;
                acc = acc - longint'(ATAN_TAB[i]);
            end
        end
        return acc;
    endfunction

    function automatic polar_t to_polar(input logic [31:0] n, input logic [31:0] w,
                                        input logic [31:0] u);
        longint          x;
        longint          y;
        longint          z;
        longint          rxy;
        longint          r;
        longint          a;
        longint          b;
        longint          e;
        longint unsigned code;
        longint unsigned rng;
        logic [31:0]     ua;
        polar_t          res;
        x = longint'($signed(n)) <<< GUARD;
        y = longint'($signed(w)) <<< GUARD;
        z = longint'($signed(u)) <<< GUARD;
        spin(x, y, {az_offset, 16'h0});
        x = q31_mul(x, inv_k);
        y = q31_mul(y, inv_k);
        spin(z, x, {el_tilt, 16'h0});
        z = q31_mul(z, inv_k);
        x = q31_mul(x, inv_k);
        if (y == 0)
        begin
            res.az = (x > 0) ? 16'h0000 : 16'h8000;
            rxy = (x < 0) ? -x : x;
        end
        else
        begin
            a = x;
            b = y;
            ua = 32'(aim(a, b));
            code = ((longint'(ua) + 64'd32768) >> 16) & 64'hFFFF;
            res.az = code[15:0];
            rxy = q31_mul(a, inv_k);
        end
        if (z == 0)
        begin
            res.el = 16'h0000;
            r = rxy;
        end
        else
        begin
            a = rxy;
            b = z;
            e = aim(a, b);
            if (e > (64'sd1 <<< 30))
                e = 64'sd1 <<< 30;
            if (e < -(64'sd1 <<< 30))
                e = -(64'sd1 <<< 30);
            e = (e + 64'sd32768) >>> 16;
            res.el = e[15:0];
            r = q31_mul(a, inv_k);
        end
        if (r < 0)
            r = 0;
        rng = (longint'(r) + (64'd1 << (GUARD - 1))) >> GUARD;
        res.rng = (rng > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rng[31:0];
        return res;
    endfunction

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $time, what);
        errors++;
    endtask

    initial
    begin
        longint a;
        longint b;
        longint ang;
        errors = 0;
        pending = 0;
        a = 64'sd1 <<< 30;
        b = 0;
        ang = aim(a, b);
        if (a <= 0)
            a = 1;
        inv_k = ((64'd1 << 61) + longint'(a) / 2) / longint'(a);
    end

    always @(posedge clk or negedge rst_n)
    begin
        polar_t want;
        if (!rst_n)
        begin
            polar_q.delete();
            az_offset <= '0;
            el_tilt <= '0;
            pending = 0;
        end
        else
        begin
            if (done)
            begin
                if (polar_q.size() == 0)
                begin
                    report("result with no item waiting");
                end
                else
                begin
                    want = polar_q.pop_front();
                    if (azimuth !== want.az)
                        report($sformatf("azimuth %0d, want %0d",
                                         $signed(azimuth), $signed(want.az)));
                    if (elevation !== want.el)
                        report($sformatf("elevation %0d, want %0d",
                                         $signed(elevation), $signed(want.el)));
                    if (range_len !== want.rng)
                        report($sformatf("range_len %0d, want %0d", range_len, want.rng));
                end
            end
            if (start && !busy)
                polar_q.push_back(to_polar(pos_north, pos_west, pos_up));
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_AZIMUTH_OFFSET)
                    az_offset <= cfg_data;
                else if (cfg_index == CFG_ELEVATION_TILT)
                    el_tilt <= cfg_data;
            end
            pending = polar_q.size();
        end
    end

endmodule

// ===== verif/tb.sv =====
// Testbench top: drives targets and angle settings into the block and gives the verdict.
module tb
    import rtas_pkg::*;
;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] pos_north;
    logic [31:0] pos_west;
    logic [31:0] pos_up;
    logic        done;
    logic [15:0] azimuth;
    logic [15:0] elevation;
    logic [31:0] range_len;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [15:0] cfg_data;
    int          errors;
    int          pending;

    rotate_to_antenna_spherical uut (.*);

    rtas_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(12 * 400000);
        $display("status: fail");
        $finish;
    end

    function automatic logic [31:0] pick_coord();
        int mode;
        logic [31:0] v;
        mode = $urandom_range(0, 9);
        v = $urandom;
        if (mode < 4)
            return v;
        if (mode < 8)
            return 32'($signed(v) >>> $urandom_range(1, 31));
        if (mode == 8)
            return 32'h0;
        return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endfunction

    // Item stays on the ports; start is left high for a following item.
    task automatic put(input logic [31:0] n, input logic [31:0] w, input logic [31:0] u);
        start <= 1'b1;
        pos_north <= n;
        pos_west <= w;
        pos_up <= u;
        do
            @(negedge clk);
        while (busy);
        @(posedge clk);
    endtask

    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Valid is left high for a following write; the caller drops it.
    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(negedge clk);
        while (!cfg_ready);
        @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic random_items(input int count);
        int left;
        int burst;
        left = count;
        while (left > 0)
        begin
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 12);
            repeat (burst)
                put(pick_coord(), pick_coord(), pick_coord());
            left -= burst;
            if ($urandom_range(0, 2) != 0)
                hold_off($urandom_range(1, 9));
        end
    endtask

    initial
    begin
        logic [15:0] az_set [6];
        logic [15:0] el_set [6];
        start = 1'b0;
        pos_north = '0;
        pos_west = '0;
        pos_up = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset angles: origin, axes, extremes of each field
        put(32'h0, 32'h0, 32'h0);
        put(32'h100, 32'h0, 32'h0);
        put(32'hFFFF_FF00, 32'h0, 32'h0);
        put(32'h0, 32'h100, 32'h0);
        put(32'h0, 32'hFFFF_FF00, 32'h0);
        put(32'h0, 32'h0, 32'h100);
        put(32'h0, 32'h0, 32'hFFFF_FF00);
        put(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        put(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        put(32'h8000_0000, 32'h0, 32'h0);
        put(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        put(32'h0, 32'h0, 32'h7FFF_FFFF);
        put(32'h1, 32'h1, 32'h1);
        put(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        put(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        put(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        hold_off(3);
        random_items(250);
        drain();

        az_set = '{16'h7FFF, 16'h8000, 16'h4000, 16'hC000, 16'h0000, 16'h0000};
        el_set = '{16'h8000, 16'h7FFF, 16'hC000, 16'h4000, 16'h2000, 16'h0000};
        for (int ph = 0; ph < 7; ph++)
        begin
            if (ph < 6)
            begin
                write_reg(CFG_AZIMUTH_OFFSET, az_set[ph]);
                write_reg(CFG_ELEVATION_TILT, el_set[ph]);
            end
            else
            begin
                write_reg(CFG_AZIMUTH_OFFSET, 16'($urandom));
                write_reg(CFG_ELEVATION_TILT, 16'($urandom));
            end
            // Unknown indexes must leave the angles alone
            write_reg(8'd2, 16'($urandom));
            write_reg(8'hFF, 16'($urandom));
            cfg_valid <= 1'b0;
            put(32'h0, 32'h0, 32'h0);
            put(32'h1000, 32'h0, 32'h0);
            put(32'h0, 32'h0, 32'h1000);
            random_items(230);
            drain();
        end

        if (errors == 0 && pending == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== rotate_to_antenna_spherical.f =====
hw/rtl/rtas_pkg.sv
hw/rtl/rtas_cell.sv
hw/rtl/rtas_row.sv
hw/rtl/rtas_scale.sv
hw/rtl/rotate_to_antenna_spherical.sv
verif/rtas_checker.sv
verif/tb.sv
